[hw/rtl/pim_pkg.sv]
package pim_pkg;

  // wait list geometry and field widths
  localparam int MaxWaiters = 16;
  localparam int AddrW      = $clog2(MaxWaiters);
  localparam int CntW       = $clog2(MaxWaiters + 1);
  localparam int IdW        = 8;
  localparam int PrioW      = 8;

  // command codes
  localparam logic CmdLock   = 1'b0;
  localparam logic CmdUnlock = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StScan,
    StLockEnd,
    StPick,
    StShift,
    StFinish
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic grant;
    logic release_lock;
    logic scan_start;
    logic scan;
    logic lock_end;
    logic pick;
    logic shift;
    logic shift_end;
    logic emit;
  } pim_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_unlock;
    logic present;
    logic held;
    logic cnt_zero;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } pim_sts_t;

endpackage

[hw/rtl/pim_req_if.sv]
interface pim_req_if import pim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [IdW-1:0]   task_id;
  logic [PrioW-1:0] task_priority;
  logic             requester_present;

  modport source (output valid, command, task_id, task_priority, requester_present,
                  input ready);
  modport sink   (input valid, command, task_id, task_priority, requester_present,
                  output ready);
endinterface

[hw/rtl/pim_rsp_if.sv]
interface pim_rsp_if import pim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             granted;
  logic             queued;
  logic             list_full;
  logic             boost_valid;
  logic [PrioW-1:0] boost_priority;
  logic             restore_valid;
  logic [IdW-1:0]   restore_task;
  logic             wake_valid;
  logic [IdW-1:0]   wake_task;
  logic             is_locked;
  logic [IdW-1:0]   owner_task;
  logic [CntW-1:0]  waiter_count;

  modport source (output valid, granted, queued, list_full, boost_valid, boost_priority,
                  restore_valid, restore_task, wake_valid, wake_task, is_locked,
                  owner_task, waiter_count,
                  input ready);
  modport sink   (input valid, granted, queued, list_full, boost_valid, boost_priority,
                  restore_valid, restore_task, wake_valid, wake_task, is_locked,
                  owner_task, waiter_count,
                  output ready);
endinterface

[hw/rtl/pim_cfg_if.sv]
interface pim_cfg_if import pim_pkg::*; ();
  logic valid;
  logic ready;
  logic inherit_enable;

  modport source (output valid, inherit_enable, input ready);
  modport sink   (input valid, inherit_enable, output ready);
endinterface

[hw/rtl/pim_ctrl.sv]
module pim_ctrl import pim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  pim_sts_t sts_i,
  output pim_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        if (!sts_i.is_unlock) begin
          if (!sts_i.present) begin
            state_d = StFinish;
          end else if (!sts_i.held) begin
            cmd_o.grant = 1'b1;
            state_d     = StFinish;
          end else if (sts_i.cnt_zero) begin
            state_d = StLockEnd;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
        end else begin
          if (!sts_i.held) begin
            state_d = StFinish;
          end else if (sts_i.cnt_zero) begin
            cmd_o.release_lock = 1'b1;
            state_d            = StFinish;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = sts_i.is_unlock ? StPick : StLockEnd;
        end
      end
      StLockEnd: begin
        cmd_o.lock_end = 1'b1;
        state_d        = StFinish;
      end
      StPick: begin
        cmd_o.pick = 1'b1;
        state_d    = StShift;
      end
      StShift: begin
        if (sts_i.shift_done) begin
          cmd_o.shift_end = 1'b1;
          state_d         = StFinish;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

[hw/rtl/pim_dp.sv]
module pim_dp import pim_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  pim_req_if.sink       req_i,
  pim_rsp_if.source     rsp_o,
  pim_cfg_if.sink       cfg_i,
  input  pim_cmd_t      cmd_i,
  output pim_sts_t      sts_o
);

  // wait list storage
  logic [IdW-1:0]   id_mem   [MaxWaiters];
  logic [PrioW-1:0] prio_mem [MaxWaiters];

  // mutex state
  logic             held_q;
  logic [IdW-1:0]   holder_id_q;
  logic [PrioW-1:0] holder_prio_q;
  logic [CntW-1:0]  count_q;
  logic             inherit_q;

  // captured item
  logic             item_cmd_q;
  logic [IdW-1:0]   item_id_q;
  logic [PrioW-1:0] item_prio_q;
  logic             item_present_q;

  // scan pointer, read pipeline and search results
  logic [CntW-1:0]  idx_q;
  logic             rd_vld_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [IdW-1:0]   rd_id_q;
  logic [PrioW-1:0] rd_prio_q;
  logic             found_q;
  logic [AddrW-1:0] best_addr_q;
  logic [IdW-1:0]   best_id_q;
  logic [PrioW-1:0] best_prio_q;

  // result staging
  logic             granted_q, queued_q, full_q, boost_v_q, restore_v_q, wake_v_q;
  logic [PrioW-1:0] boost_p_q;
  logic [IdW-1:0]   restore_t_q, wake_t_q;

  // output register
  logic             out_vld_q;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [IdW-1:0]   wr_id;
  logic [PrioW-1:0] wr_prio;
  logic             eval_best;
  logic             room;
  logic             boost;

  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_vld_q;

  // memory port control
  assign rd_en     = (cmd_i.scan || cmd_i.shift) && (idx_q < count_q);
  assign rd_addr   = idx_q[AddrW-1:0];
  assign room      = count_q < CntW'(MaxWaiters);
  assign boost     = inherit_q && (item_prio_q > holder_prio_q);
  assign eval_best = (rd_addr_q == '0) || (rd_prio_q > best_prio_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AddrW-1:0];
    wr_id   = item_id_q;
    wr_prio = item_prio_q;
    if (cmd_i.lock_end) begin
      wr_en = !found_q && room;
    end else if (cmd_i.shift && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_q - AddrW'(1);
      wr_id   = rd_id_q;
      wr_prio = rd_prio_q;
    end
  end

  // wait list memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr]   <= wr_id;
      prio_mem[wr_addr] <= wr_prio;
    end
    if (rd_en) begin
      rd_id_q   <= id_mem[rd_addr];
      rd_prio_q <= prio_mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.is_unlock  = (item_cmd_q == CmdUnlock);
    sts_o.present    = item_present_q;
    sts_o.held       = held_q;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.scan_done  = rd_vld_q && (CntW'(rd_addr_q) == count_q - CntW'(1));
    sts_o.shift_done = (idx_q >= count_q) && !rd_vld_q;
    sts_o.out_free   = !out_vld_q || rsp_o.ready;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      holder_id_q   <= '0;
      holder_prio_q <= '0;
      count_q       <= '0;
      inherit_q     <= 1'b1;
      rd_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cfg_i.valid) begin
        inherit_q <= cfg_i.inherit_enable;
      end
      if (cmd_i.grant) begin
        held_q        <= 1'b1;
        holder_id_q   <= item_id_q;
        holder_prio_q <= item_prio_q;
      end
      if (cmd_i.release_lock) begin
        held_q        <= 1'b0;
        holder_id_q   <= '0;
        holder_prio_q <= '0;
      end
      if (cmd_i.lock_end) begin
        if (!found_q && room) begin
          count_q <= count_q + CntW'(1);
        end
        if (boost) begin
          holder_prio_q <= item_prio_q;
        end
      end
      if (cmd_i.pick) begin
        holder_id_q   <= best_id_q;
        holder_prio_q <= best_prio_q;
      end
      if (cmd_i.shift_end) begin
        count_q <= count_q - CntW'(1);
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item capture, search and result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_cmd_q     <= req_i.command;
      item_id_q      <= req_i.task_id;
      item_prio_q    <= req_i.task_priority;
      item_present_q <= req_i.requester_present;
      found_q        <= 1'b0;
      granted_q      <= 1'b0;
      queued_q       <= 1'b0;
      full_q         <= 1'b0;
      boost_v_q      <= 1'b0;
      boost_p_q      <= '0;
      restore_v_q    <= 1'b0;
      restore_t_q    <= '0;
      wake_v_q       <= 1'b0;
      wake_t_q       <= '0;
    end
    if (cmd_i.grant) begin
      granted_q <= 1'b1;
    end
    if (cmd_i.release_lock || cmd_i.pick) begin
      restore_v_q <= 1'b1;
      restore_t_q <= holder_id_q;
    end
    if (cmd_i.scan_start) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end
    if (rd_en) begin
      idx_q <= idx_q + CntW'(1);
    end
    // duplicate check and best waiter search share the read stream
    if (cmd_i.scan && rd_vld_q) begin
      if (rd_id_q == item_id_q) begin
        found_q <= 1'b1;
      end
      if (eval_best) begin
        best_addr_q <= rd_addr_q;
        best_id_q   <= rd_id_q;
        best_prio_q <= rd_prio_q;
      end
    end
    if (cmd_i.lock_end) begin
      if (!found_q) begin
        queued_q <= room;
        full_q   <= !room;
      end
      if (boost) begin
        boost_v_q <= 1'b1;
        boost_p_q <= item_prio_q;
      end
    end
    if (cmd_i.pick) begin
      wake_v_q <= 1'b1;
      wake_t_q <= best_id_q;
      idx_q    <= CntW'(best_addr_q) + CntW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_o.granted        <= granted_q;
      rsp_o.queued         <= queued_q;
      rsp_o.list_full      <= full_q;
      rsp_o.boost_valid    <= boost_v_q;
      rsp_o.boost_priority <= boost_p_q;
      rsp_o.restore_valid  <= restore_v_q;
      rsp_o.restore_task   <= restore_t_q;
      rsp_o.wake_valid     <= wake_v_q;
      rsp_o.wake_task      <= wake_t_q;
      rsp_o.is_locked      <= held_q;
      rsp_o.owner_task     <= held_q ? holder_id_q : '0;
      rsp_o.waiter_count   <= count_q;
    end
  end

endmodule

[hw/rtl/priority_inheritance_mutex.sv]
// lock on a free mutex, null lock, unlock that hands to no waiter: no wait list access
// lock on a held mutex: empty list queues directly, else a dup scan reads one entry a cycle
// unlock with waiters: scan for the best waiter, pick it, shift the later entries down
// throughput: one word at a time, next word taken when the controller returns to idle
// reset: mutex free, wait list empty, inheritance enabled; list storage is not cleared
module priority_inheritance_mutex import pim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pim_req_if.sink   req_i,
  pim_rsp_if.source rsp_o,
  pim_cfg_if.sink   cfg_i
);

  pim_cmd_t cmd;
  pim_sts_t sts;

  // sequencer
  pim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // state, wait list and result register
  pim_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
